/* hdl/spq_pkg.sv */
// ---------------------------------------------------------------------------
// spq_pkg - shared types and constants for the sorted insert priority queue
// Holds the payload structs, the status codes and the control struct that
// goes from the top level to every storage cell.
// ---------------------------------------------------------------------------
package spq_pkg;

  localparam int DATA_W       = 32;
  localparam int OCC_W        = 5;
  localparam int CAPACITY_DEF = 16;

  // Operation codes carried in the mode field
  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic                     mode;
    logic signed [DATA_W-1:0] value;
  } in_t;

  typedef struct packed {
    status_t                  status;
    logic signed [DATA_W-1:0] removed_value;
    logic [OCC_W-1:0]         occupancy;
  } out_t;

  // Broadcast to all cells for one transaction
  typedef struct packed {
    logic                     enq;
    logic                     deq;
    logic signed [DATA_W-1:0] value;
  } spq_ctrl_t;

endpackage

/* hdl/spq_cell.sv */
// ---------------------------------------------------------------------------
// spq_cell - one slot of the sorted shift-register queue
// Holds one value, compares it with the broadcast insert value and takes
// its own, the new, or a neighbour's value on each transaction.
// ---------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  logic                     clk,
  input  spq_ctrl_t                ctrl,
  input  logic [CNT_W-1:0]         count,
  input  logic signed [DATA_W-1:0] left_value,
  input  logic                     left_ins,
  input  logic signed [DATA_W-1:0] right_value,
  output logic signed [DATA_W-1:0] value,
  output logic                     ins
);

  logic signed [DATA_W-1:0] stored;
  logic signed [DATA_W-1:0] stored_next;
  logic                     occupied;

  // Slot lies at or behind the insertion point: empty, or holds a greater value
  assign occupied = CNT_W'(IDX) < count;
  assign ins      = !occupied || (stored > ctrl.value);
  assign value    = stored;

  // Dequeue shifts toward the head; enqueue shifts toward the tail from the slot on
  always_comb begin
    stored_next = stored;
    if (ctrl.deq) begin
      stored_next = right_value;
    end else if (ctrl.enq && ins) begin
      stored_next = left_ins ? left_value : ctrl.value;
    end
  end

  always_ff @(posedge clk) begin
    stored <= stored_next;
  end

endmodule

/* hdl/sorted_insert_priority_queue_top.sv */
// ---------------------------------------------------------------------------
// sorted_insert_priority_queue_top - minimum priority queue, sorted cells
// Row of CAPACITY cells kept in ascending order; equal values leave FIFO.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall/in_data) carries one operation per
//   transaction: mode 0 enqueues in_data.value, mode 1 dequeues the minimum.
//   Output channel (out_valid/out_stall/out_data) returns exactly one result
//   per operation: status, removed value (-1 when empty, 0 for enqueue) and
//   the occupancy after the operation.
//   The result is registered at the edge that accepts the operation.
//   Throughput is one operation per cycle while no result waits stalled, set
//   by the cell row, where every cell compares against the broadcast value
//   and shifts in the same cycle.
//   When the receiver stalls, the result register holds and in_stall rises
//   until that result is taken; nothing is lost or repeated.
//   Reset (rst, synchronous) empties the queue and clears out_valid; cell
//   contents are left as they were and are never read until rewritten.
// ---------------------------------------------------------------------------
module sorted_insert_priority_queue_top
  import spq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;
  logic                     accept;
  logic                     full;
  logic                     empty;
  spq_ctrl_t                ctrl;
  out_t                     result;
  logic signed [DATA_W-1:0] cell_value [CAPACITY];
  logic                     cell_ins   [CAPACITY];

  // Handshake: take a new transaction unless a result waits stalled
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = count == CNT_W'(CAPACITY);
  assign empty    = count == '0;

  // Broadcast control to the cells
  always_comb begin
    ctrl.enq   = accept && (in_data.mode == MODE_ENQ) && !full;
    ctrl.deq   = accept && (in_data.mode == MODE_DEQ) && !empty;
    ctrl.value = in_data.value;
  end

  // Count update and result formation
  always_comb begin
    count_next           = count;
    result.status        = ST_DONE;
    result.removed_value = '0;
    if (in_data.mode == MODE_ENQ) begin
      if (full) begin
        result.status = ST_FULL;
      end else begin
        count_next = count + CNT_W'(1);
      end
    end else begin
      if (empty) begin
        result.status        = ST_EMPTY;
        result.removed_value = '1;
      end else begin
        result.removed_value = cell_value[0];
        count_next           = count - CNT_W'(1);
      end
    end
    result.occupancy = OCC_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

  // Cell row: head at index 0
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_value;
    logic                     left_ins;
    logic signed [DATA_W-1:0] right_value;

    if (i == 0) begin : g_head
      assign left_value = '0;
      assign left_ins   = 1'b0;
    end else begin : g_body
      assign left_value = cell_value[i-1];
      assign left_ins   = cell_ins[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_value = '0;
    end else begin : g_inner
      assign right_value = cell_value[i+1];
    end

    spq_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .count       (count),
      .left_value  (left_value),
      .left_ins    (left_ins),
      .right_value (right_value),
      .value       (cell_value[i]),
      .ins         (cell_ins[i])
    );
  end

endmodule

/* hdl/spq_checker.sv */
// ---------------------------------------------------------------------------
// spq_checker - port-level checks for the sorted insert priority queue
// Watches the top level's channels and the consistency of its results.
// ---------------------------------------------------------------------------
module spq_checker
  import spq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Every accepted transaction yields a result on the next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted transaction gave no result");

  // Input side stalls only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting result");

  // Empty dequeue reports -1 and zero occupancy
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_EMPTY |->
      out_data.removed_value == -32'sd1 && out_data.occupancy == '0)
    else $error("bad empty-queue result");

  // Rejected enqueue reports a full queue
  a_full_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_FULL |->
      out_data.removed_value == '0 && out_data.occupancy == OCC_W'(CAPACITY))
    else $error("bad full-queue result");

endmodule

bind sorted_insert_priority_queue_top spq_checker #(
  .CAPACITY (CAPACITY)
) u_spq_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
